[src/bba_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// bba_pkg
// Shared types and constants of the bitmap block allocator: bitmap geometry,
// request and status codes, controller states and the bitmap write bundle.
// ---------------------------------------------------------------------------
package bba_pkg;

  // bitmap geometry
  localparam int BITMAP_BYTES = 1024;
  localparam int BYTE_W       = 8;
  localparam int WORD_BYTES   = 8;
  localparam int WORD_W       = WORD_BYTES * BYTE_W;
  localparam int WORDS        = BITMAP_BYTES / WORD_BYTES;
  localparam int WADDR_W      = $clog2(WORDS);
  localparam int BSEL_W       = $clog2(WORD_BYTES);
  localparam int KSEL_W       = $clog2(BYTE_W);
  localparam int BIT_W        = $clog2(WORD_W);
  localparam int WLIM_W       = $clog2(WORDS + 1);

  // summary scan geometry
  localparam int SCAN_W       = 16;
  localparam int GROUPS       = WORDS / SCAN_W;
  localparam int GRP_W        = $clog2(GROUPS);
  localparam int OFF_W        = $clog2(SCAN_W);

  // field widths
  localparam int BLOCK_W      = 13;
  localparam int STATUS_W     = 2;
  localparam int LIM_W        = 11;

  // request codes
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_ALLOC = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MOD
  } ctrl_state_t;

  // one bitmap word write, with the word's new full flag
  typedef struct packed {
    logic               en;
    logic [WADDR_W-1:0] addr;
    logic [WORD_W-1:0]  data;
    logic               full;
  } wr_t;

endpackage
`default_nettype wire

[src/bba_if.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// bba channel interfaces
// Request, response and configuration channels, each with valid and ready.
// ---------------------------------------------------------------------------
interface bba_req_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [bba_pkg::BLOCK_W-1:0] block_number;

  modport source (output valid, func, block_number, input ready);
  modport sink   (input valid, func, block_number, output ready);
endinterface

interface bba_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [bba_pkg::STATUS_W-1:0] status;
  logic [bba_pkg::BLOCK_W-1:0]  allocated_block;

  modport source (output valid, status, allocated_block, input ready);
  modport sink   (input valid, status, allocated_block, output ready);
endinterface

interface bba_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [bba_pkg::LIM_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

[src/bba_bitmap_mem.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// bba_bitmap_mem
// Bitmap storage: one word of eight bitmap bytes per entry, registered
// read. A per-word valid bit makes unwritten words read as zero.
// ---------------------------------------------------------------------------
module bba_bitmap_mem (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        rd_en,
  input  wire logic [bba_pkg::WADDR_W-1:0] rd_addr,
  output logic      [bba_pkg::WORD_W-1:0]  rd_data,
  input  wire bba_pkg::wr_t                wr
);

  logic [bba_pkg::WORD_W-1:0] mem [bba_pkg::WORDS];
  logic [bba_pkg::WORDS-1:0]  valid;

  // storage array
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // written-word flags, all clear after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.addr] <= 1'b1;
    end
  end

  // registered read, unwritten words are all free
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= valid[rd_addr] ? mem[rd_addr] : '0;
    end
  end

endmodule
`default_nettype wire

[src/bba_summary.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// bba_summary
// One full flag per bitmap word. Looks at one group of flags per cycle and
// returns the first word in the group that has a clear bit and lies inside
// the search bound.
// ---------------------------------------------------------------------------
module bba_summary (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire bba_pkg::wr_t                wr,
  input  wire logic [bba_pkg::GRP_W-1:0]   grp,
  input  wire logic [bba_pkg::WLIM_W-1:0]  words_lim,
  output logic                             hit,
  output logic      [bba_pkg::OFF_W-1:0]   hit_off
);

  logic [bba_pkg::WORDS-1:0]  full;
  logic [bba_pkg::SCAN_W-1:0] cand;

  // full flags follow every word write
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= '0;
    end else if (wr.en) begin
      full[wr.addr] <= wr.full;
    end
  end

  // candidate words of the selected group
  always_comb begin
    logic [bba_pkg::WADDR_W-1:0] widx;
    for (int i = 0; i < bba_pkg::SCAN_W; i++) begin
      widx    = {grp, bba_pkg::OFF_W'(i)};
      cand[i] = !full[widx] && ({1'b0, widx} < words_lim);
    end
  end

  // lowest candidate wins
  always_comb begin
    hit     = 1'b0;
    hit_off = '0;
    for (int i = bba_pkg::SCAN_W - 1; i >= 0; i--) begin
      if (cand[i]) begin
        hit     = 1'b1;
        hit_off = bba_pkg::OFF_W'(i);
      end
    end
  end

endmodule
`default_nettype wire

[src/bba_ctrl.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// bba_ctrl
// Request sequencer: holds the search bound, steps the summary scan, issues
// the bitmap read, modifies the word, writes it back and loads the response.
// ---------------------------------------------------------------------------
module bba_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  bba_req_if.sink                          req,
  bba_rsp_if.source                        rsp,
  bba_cfg_if.sink                          cfg,
  output logic                             rd_en,
  output logic      [bba_pkg::WADDR_W-1:0] rd_addr,
  input  wire logic [bba_pkg::WORD_W-1:0]  rd_data,
  output bba_pkg::wr_t                     wr,
  output logic      [bba_pkg::GRP_W-1:0]   grp,
  output logic      [bba_pkg::WLIM_W-1:0]  words_lim,
  input  wire logic                        hit,
  input  wire logic [bba_pkg::OFF_W-1:0]   hit_off
);

  bba_pkg::ctrl_state_t state, state_next;

  logic [bba_pkg::LIM_W-1:0]   lim;
  logic [bba_pkg::LIM_W-1:0]   lim_next;
  logic [bba_pkg::LIM_W-1:0]   lim_round;
  logic                        func_r;
  logic [bba_pkg::BLOCK_W-1:0] blk_r;
  logic [bba_pkg::WADDR_W-1:0] word;
  logic                        found;
  logic                        load;
  bba_pkg::status_t            res_status;
  logic [bba_pkg::BLOCK_W-1:0] res_block;
  logic                        rsp_valid;
  bba_pkg::status_t            rsp_status;
  logic [bba_pkg::BLOCK_W-1:0] rsp_block;
  logic                        req_fire;

  // allocation search inside the read word
  logic [bba_pkg::WORD_BYTES-1:0] byte_ok;
  logic                           byte_hit;
  logic [bba_pkg::BSEL_W-1:0]     sel_j;
  logic [bba_pkg::BYTE_W-1:0]     sel_byte;
  logic [bba_pkg::KSEL_W-1:0]     sel_k;
  logic [bba_pkg::BIT_W-1:0]      alloc_bit;
  logic [bba_pkg::WORD_W-1:0]     alloc_word;
  logic [bba_pkg::WORD_W-1:0]     free_word;

  assign req_fire = req.valid && req.ready;
  assign load     = !rsp_valid || rsp.ready;

  // search bound, clamped to the bitmap
  assign cfg.ready = 1'b1;
  assign lim_next  = (cfg.data > bba_pkg::LIM_W'(bba_pkg::BITMAP_BYTES)) ?
                     bba_pkg::LIM_W'(bba_pkg::BITMAP_BYTES) : cfg.data;
  assign lim_round = lim + bba_pkg::LIM_W'(bba_pkg::WORD_BYTES - 1);
  assign words_lim = bba_pkg::WLIM_W'(lim_round >> bba_pkg::BSEL_W);

  always_ff @(posedge clk) begin
    if (rst) begin
      lim <= bba_pkg::LIM_W'(bba_pkg::BITMAP_BYTES);
    end else if (cfg.valid && cfg.ready) begin
      lim <= lim_next;
    end
  end

  // bytes of the word that lie in the bound and have a clear bit
  always_comb begin
    for (int j = 0; j < bba_pkg::WORD_BYTES; j++) begin
      byte_ok[j] = ({1'b0, word, bba_pkg::BSEL_W'(j)} < lim) &&
                   (rd_data[j*bba_pkg::BYTE_W +: bba_pkg::BYTE_W] != '1);
    end
  end

  // first such byte, then its first clear bit
  always_comb begin
    byte_hit = 1'b0;
    sel_j    = '0;
    for (int j = bba_pkg::WORD_BYTES - 1; j >= 0; j--) begin
      if (byte_ok[j]) begin
        byte_hit = 1'b1;
        sel_j    = bba_pkg::BSEL_W'(j);
      end
    end
    sel_byte = rd_data[sel_j*bba_pkg::BYTE_W +: bba_pkg::BYTE_W];
    sel_k    = '0;
    for (int k = bba_pkg::BYTE_W - 1; k >= 0; k--) begin
      if (!sel_byte[k]) begin
        sel_k = bba_pkg::KSEL_W'(k);
      end
    end
  end

  assign alloc_bit  = {sel_j, sel_k};
  assign alloc_word = rd_data | (bba_pkg::WORD_W'(1) << alloc_bit);
  assign free_word  = rd_data & ~(bba_pkg::WORD_W'(1) << blk_r[bba_pkg::BIT_W-1:0]);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bba_pkg::S_IDLE: begin
        if (req_fire) begin
          state_next = (req.func == bba_pkg::FUNC_FREE) ? bba_pkg::S_MOD : bba_pkg::S_SCAN;
        end
      end
      bba_pkg::S_SCAN: begin
        if (hit || grp == bba_pkg::GRP_W'(bba_pkg::GROUPS - 1)) begin
          state_next = bba_pkg::S_MOD;
        end
      end
      bba_pkg::S_MOD: begin
        if (load) begin
          state_next = bba_pkg::S_IDLE;
        end
      end
      default: state_next = bba_pkg::S_IDLE;
    endcase
  end

  // outputs of each state
  always_comb begin
    req.ready  = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = {grp, hit_off};
    wr         = '0;
    res_status = bba_pkg::ST_DONE;
    res_block  = '0;
    unique case (state)
      bba_pkg::S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid && req.func == bba_pkg::FUNC_FREE) begin
          rd_en   = 1'b1;
          rd_addr = req.block_number[bba_pkg::BLOCK_W-1:bba_pkg::BIT_W];
        end
      end
      bba_pkg::S_SCAN: begin
        rd_en = hit;
      end
      bba_pkg::S_MOD: begin
        if (func_r == bba_pkg::FUNC_FREE) begin
          wr.addr = blk_r[bba_pkg::BLOCK_W-1:bba_pkg::BIT_W];
          wr.data = free_word;
          wr.full = 1'b0;
          if (rd_data[blk_r[bba_pkg::BIT_W-1:0]]) begin
            wr.en = load;
          end else begin
            res_status = bba_pkg::ST_NOT_ALLOC;
          end
        end else begin
          wr.addr = word;
          wr.data = alloc_word;
          wr.full = &alloc_word;
          if (found && byte_hit) begin
            wr.en     = load;
            res_block = {word, alloc_bit};
          end else begin
            res_status = bba_pkg::ST_FULL;
          end
        end
      end
      default: begin
        req.ready = 1'b0;
      end
    endcase
  end

  // state and request registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bba_pkg::S_IDLE;
      grp   <= '0;
    end else begin
      state <= state_next;
      if (state == bba_pkg::S_IDLE) begin
        grp <= '0;
      end else if (state == bba_pkg::S_SCAN) begin
        grp <= grp + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      func_r <= req.func;
      blk_r  <= req.block_number;
    end
    if (state == bba_pkg::S_SCAN) begin
      found <= hit;
      word  <= {grp, hit_off};
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == bba_pkg::S_MOD && load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == bba_pkg::S_MOD && load) begin
      rsp_status <= res_status;
      rsp_block  <= res_block;
    end
  end

  assign rsp.valid           = rsp_valid;
  assign rsp.status          = rsp_status;
  assign rsp.allocated_block = rsp_block;

endmodule
`default_nettype wire

[src/bitmap_block_allocator_core.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// bitmap_block_allocator_core
// First-fit free-block bitmap allocator, one bit per disk block.
// ---------------------------------------------------------------------------
// Channels: req carries func (0 allocate, 1 free) and block_number; rsp
// returns status and allocated_block, one response per request; cfg writes
// the number of bitmap bytes that allocation searches (clamped to 1024).
// The bitmap is held as 128 words of 64 bits in a registered-read memory,
// plus one full flag per word for the search.
// A free reads its word when the request is taken, then clears the bit and
// writes the word back in the modify step. An allocate scans the full flags
// 16 words per cycle, up to 8 groups, then reads and updates one word.
// One request is in work at a time; the rate is set by the flag scan and
// the read-modify-write of the memory.
// A new request is taken while an earlier response still waits in the
// output register; if the receiver stalls, the next response waits in the
// modify step until that register empties.
// Reset: every block free, search bound 1024 bytes. No clearing pass is
// needed, a word never written reads as all free.
// ---------------------------------------------------------------------------
module bitmap_block_allocator_core (
  input  wire logic clk,
  input  wire logic rst,
  bba_req_if.sink   req,
  bba_rsp_if.source rsp,
  bba_cfg_if.sink   cfg
);

  logic                        rd_en;
  logic [bba_pkg::WADDR_W-1:0] rd_addr;
  logic [bba_pkg::WORD_W-1:0]  rd_data;
  bba_pkg::wr_t                wr;
  logic [bba_pkg::GRP_W-1:0]   grp;
  logic [bba_pkg::WLIM_W-1:0]  words_lim;
  logic                        hit;
  logic [bba_pkg::OFF_W-1:0]   hit_off;

  // bitmap words
  bba_bitmap_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (wr)
  );

  // per-word full flags and group scan
  bba_summary u_summary (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .grp       (grp),
    .words_lim (words_lim),
    .hit       (hit),
    .hit_off   (hit_off)
  );

  // request sequencer
  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cfg       (cfg),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr        (wr),
    .grp       (grp),
    .words_lim (words_lim),
    .hit       (hit),
    .hit_off   (hit_off)
  );

endmodule
`default_nettype wire
